// ===== sv/sfr_pkg.sv =====
// ============================================================================
// sfr_pkg
// Shared types and constants for the stream find-and-replace block.
// ============================================================================
`timescale 1ns / 1ps

package sfr_pkg;

    // Longest pattern the window can hold
    localparam int MAX_PATTERN = 8;
    // Longest replacement emitted per match
    localparam int REPL_CAP    = 8;
    // Bytes one back-end job can carry
    localparam int JOB_BYTES   = (MAX_PATTERN > REPL_CAP) ? MAX_PATTERN : REPL_CAP;
    localparam int JOB_W       = JOB_BYTES * 8;
    localparam int WIN_W       = MAX_PATTERN * 8;
    // Wide enough to hold JOB_BYTES itself
    localparam int CNT_W       = $clog2(JOB_BYTES + 1);

    // Configuration register layout
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int LEN_W       = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH = 2'd3;

    // Job queue between front and back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Input request
    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_end;
    } text_t;

    // Output request
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       run_last;
        logic       text_done;
    } result_t;

    // One classified input: bytes to emit, oldest in the lowest byte
    typedef struct packed {
        logic [JOB_W-1:0] bytes;
        logic [CNT_W-1:0] count;
        logic             last;
    } job_t;

endpackage

// ===== sv/sfr_front.sv =====
// ============================================================================
// sfr_front
// Holds configuration and the pending window; turns each input byte into
// at most one job: the bytes it releases and whether it ends the text.
// ============================================================================
`timescale 1ns / 1ps

module sfr_front
    import sfr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  logic                  text_valid,
    output logic                  text_ready,
    input  text_t                 text,
    // queue write side
    input  logic                  queue_full,
    output logic                  push,
    output job_t                  push_job
);

    // Configuration registers
    logic [63:0]      pattern_bytes_reg;
    logic [LEN_W-1:0] pattern_length_reg;
    logic [63:0]      replacement_bytes_reg;
    logic [LEN_W-1:0] replacement_length_reg;

    // Pending window
    logic [7:0]       win_reg  [MAX_PATTERN];
    logic [7:0]       win_next [MAX_PATTERN];
    logic [7:0]       win_fill [MAX_PATTERN];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic [CNT_W-1:0] plen;
    logic [CNT_W-1:0] rlen;
    logic [CNT_W-1:0] cnt1;
    logic [WIN_W-1:0] fill_flat;
    logic [JOB_W-1:0] pat_ext;
    logic             accept;
    logic             full_cmp;
    logic             hit;
    logic             miss;

    assign text_ready = !queue_full;
    assign accept     = text_valid && text_ready;

    // Saturate lengths
    always_comb
    begin
        if (32'(pattern_length_reg) > MAX_PATTERN)
            plen = CNT_W'(MAX_PATTERN);
        else
            plen = CNT_W'(pattern_length_reg);
        if (replacement_length_reg > LEN_W'(REPL_CAP))
            rlen = CNT_W'(REPL_CAP);
        else
            rlen = CNT_W'(replacement_length_reg);
    end

    assign cnt1    = count_reg + CNT_W'(1);
    assign pat_ext = JOB_W'(pattern_bytes_reg);

    // Window with the new byte written at the fill position
    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            win_fill[k]          = (CNT_W'(k) == count_reg) ? text.text_byte : win_reg[k];
            fill_flat[k*8 +: 8]  = win_fill[k];
        end
    end

    // Compare the full window against the pattern
    assign full_cmp = (plen != '0) && (cnt1 == plen);
    always_comb
    begin
        hit = full_cmp;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            if ((CNT_W'(k) < plen) && (win_fill[k] != pat_ext[k*8 +: 8]))
                hit = 1'b0;
        end
    end
    assign miss = full_cmp && !hit;

    // Classify into a job and the next window state
    always_comb
    begin
        push_job.last = text.text_end;
        count_next    = count_reg;
        for (int k = 0; k < MAX_PATTERN; k++)
            win_next[k] = win_fill[k];
        priority if (plen == '0)
        begin
            push_job.bytes = JOB_W'(text.text_byte);
            push_job.count = CNT_W'(1);
            count_next     = '0;
        end
        else if (hit)
        begin
            push_job.bytes = JOB_W'(replacement_bytes_reg);
            push_job.count = rlen;
            count_next     = '0;
        end
        else
        begin
            push_job.bytes = JOB_W'(fill_flat);
            if (text.text_end)
                push_job.count = cnt1;
            else if (miss)
                push_job.count = CNT_W'(1);
            else
                push_job.count = '0;
            // drop the oldest byte on a mismatch
            if (miss)
            begin
                for (int k = 0; k + 1 < MAX_PATTERN; k++)
                    win_next[k] = win_fill[k+1];
                count_next = count_reg;
            end
            else
                count_next = cnt1;
            if (text.text_end)
                count_next = '0;
        end
    end

    assign push = accept && ((push_job.count != '0) || text.text_end);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg              <= '0;
            pattern_bytes_reg      <= '0;
            pattern_length_reg     <= '0;
            replacement_bytes_reg  <= '0;
            replacement_length_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PATTERN_BYTES:      pattern_bytes_reg      <= cfg_data[63:0];
                    CFG_PATTERN_LENGTH:     pattern_length_reg     <= cfg_data[LEN_W-1:0];
                    CFG_REPLACEMENT_BYTES:  replacement_bytes_reg  <= cfg_data[63:0];
                    CFG_REPLACEMENT_LENGTH: replacement_length_reg <= cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            // a new pattern length discards the pending window
            if (cfg_we && (cfg_index == CFG_PATTERN_LENGTH))
                count_reg <= '0;
            else if (accept)
                count_reg <= count_next;
        end
    end

    // Window bytes (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
                win_reg[k] <= win_next[k];
        end
    end

endmodule

// ===== sv/sfr_queue.sv =====
// ============================================================================
// sfr_queue
// Small job FIFO that decouples the classifying front end from the
// byte-serializing back end.
// ============================================================================
`timescale 1ns / 1ps

module sfr_queue
    import sfr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    job_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     fill_reg;

    assign full       = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + QPTR_W'(1);
            unique case ({push, pop})
                2'b10:   fill_reg <= fill_reg + (QPTR_W+1)'(1);
                2'b01:   fill_reg <= fill_reg - (QPTR_W+1)'(1);
                default: fill_reg <= fill_reg;
            endcase
        end
    end

    // Job storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== sv/sfr_back.sv =====
// ============================================================================
// sfr_back
// Sends the bytes of queued jobs one per cycle unless the receiver stalls,
// via a registered output stage; marks the last byte of each job and text.
// ============================================================================
`timescale 1ns / 1ps

module sfr_back
    import sfr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    // queue read side
    input  logic    head_valid,
    input  job_t    head_job,
    output logic    pop,
    // output channel
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    job_t             cur_reg;
    logic             cur_valid_reg;
    logic [CNT_W-1:0] idx_reg;
    result_t          res_reg;
    logic             res_valid_reg;

    result_t          item;
    logic             advance;
    logic             final_item;

    // Current byte of the job; an empty job yields a bare end marker
    assign final_item = (cur_reg.count == '0) || (idx_reg + CNT_W'(1) == cur_reg.count);
    always_comb
    begin
        item.byte_present = (cur_reg.count != '0);
        item.out_byte     = item.byte_present ? cur_reg.bytes[idx_reg*8 +: 8] : 8'd0;
        item.run_last     = final_item;
        item.text_done    = final_item && cur_reg.last;
    end

    assign advance = cur_valid_reg && (!res_valid_reg || result_ready);
    assign pop     = head_valid && (!cur_valid_reg || (advance && final_item));

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // Job sequencing and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (advance && final_item)
                cur_valid_reg <= 1'b0;
            else if (advance)
                idx_reg <= idx_reg + CNT_W'(1);

            if (advance)
                res_valid_reg <= 1'b1;
            else if (result_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head_job;
        if (advance)
            res_reg <= item;
    end

endmodule

// ===== sv/stream_find_and_replace.sv =====
// ============================================================================
// stream_find_and_replace
// Streaming byte rewriter: replaces each non-overlapping pattern match,
// found greedily left to right, with a replacement string.
// ============================================================================
// Usage:
//   Input channel text_valid/text_ready/text carries one byte per request,
//   with text_end set on the final byte of a text. Output channel
//   result_valid/result_ready/result carries one output byte per request;
//   run_last marks the last byte caused by an input byte, text_done the
//   last byte of a text. A text ending on an empty match yields one marker
//   with byte_present low.
//   Configuration is written over cfg_we/cfg_index/cfg_data while idle;
//   writing the pattern length discards the pending window.
//   The first result passes the job queue, the back end's job register and
//   the output register. Throughput: one output byte per cycle, set by the
//   back-end serializer, while the receiver does not stall; an input byte
//   producing n results (n up to 8) holds the back end until all are sent,
//   while the two-entry queue lets plain text flow at one byte per cycle.
//   Reset clears the window, the queue, the output stage and the configuration.
//   When the receiver stalls, the output holds, the queue fills, and
//   text_ready drops once two jobs are waiting.
// ============================================================================
`timescale 1ns / 1ps

module stream_find_and_replace
    import sfr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  text_valid,
    output logic                  text_ready,
    input  text_t                 text,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result
);

    logic push;
    job_t push_job;
    logic queue_full;
    logic pop;
    logic head_valid;
    job_t head_job;

    sfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text       (text),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    sfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    sfr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_job     (head_job),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== sv/sfr_checker.sv =====
// ============================================================================
// sfr_checker
// Port-level checks on the find-and-replace block, bound to its top level.
// ============================================================================
`timescale 1ns / 1ps

module sfr_checker
    import sfr_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cfg_we,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data,
    input logic                  text_valid,
    input logic                  text_ready,
    input text_t                 text,
    input logic                  result_valid,
    input logic                  result_ready,
    input result_t               result
);

    // Stalled output request holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // End of text always closes the run
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.text_done |-> result.run_last)
        else $error("text_done without run_last");

    // Empty marker only as the end of a text, with a zero byte
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.byte_present |->
            result.text_done && (result.out_byte == 8'd0))
        else $error("bad empty marker");

    // Nothing is offered while in reset
    a_reset: assert property (@(posedge clk)
        !rst_n |-> !result_valid)
        else $error("result valid in reset");

endmodule

bind stream_find_and_replace sfr_checker u_sfr_checker (.*);

// ===== sim/rewrite_checker.sv =====
// ============================================================================
// rewrite_checker
// Watches the configuration port and both request channels of the stream
// find-and-replace block, predicts the rewritten byte stream and compares
// every output request field by field with the oldest expected one.
// ============================================================================
`timescale 1ns / 1ps

module rewrite_checker
    import sfr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  text_valid,
    input  logic                  text_ready,
    input  text_t                 text,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  result_t               result,
    output int unsigned           mismatch_count,
    output int unsigned           pending_count
);

    // Shadow copy of the configuration
    logic [CFG_DATA_W-1:0] pat_bytes;
    logic [LEN_W-1:0]      pat_len;
    logic [CFG_DATA_W-1:0] rep_bytes;
    logic [LEN_W-1:0]      rep_len;

    // Pending window, oldest byte at entry 0
    logic [7:0]  window [MAX_PATTERN];
    int          window_fill;

    // Output requests still owed by the block
    result_t     expected_q [$];

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Rewrite one input byte and queue the output requests it causes
    task automatic predict_rewrite(input text_t req);
        logic [7:0] emit [$];
        int         plen;
        int         rlen;
        int         k;
        int         n;
        bit         hit;
        result_t    r;
        plen = (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
        rlen = (rep_len > REPL_CAP) ? REPL_CAP : int'(rep_len);
        if (plen == 0)
        begin
            // no pattern: straight through
            window_fill = 0;
            emit.push_back(req.text_byte);
        end
        else
        begin
            window[window_fill] = req.text_byte;
            window_fill++;
            if (window_fill >= plen)
            begin
                hit = 1'b1;
                for (k = 0; k < plen; k++)
                    if (window[k] != pat_bytes[8*k +: 8])
                        hit = 1'b0;
                if (hit)
                begin
                    for (k = 0; k < rlen; k++)
                        emit.push_back(rep_bytes[8*k +: 8]);
                    window_fill = 0;
                end
                else
                begin
                    // release the oldest byte and slide
                    emit.push_back(window[0]);
                    for (k = 1; k < window_fill; k++)
                        window[k-1] = window[k];
                    window_fill--;
                end
            end
            // end of text flushes what is left
            if (req.text_end)
            begin
                for (k = 0; k < window_fill; k++)
                    emit.push_back(window[k]);
                window_fill = 0;
            end
        end

        n = emit.size();
        if (req.text_end && n == 0)
        begin
            // empty end marker
            r              = '0;
            r.run_last     = 1'b1;
            r.text_done    = 1'b1;
            expected_q.push_back(r);
        end
        for (k = 0; k < n; k++)
        begin
            r.out_byte     = emit[k];
            r.byte_present = 1'b1;
            r.run_last     = (k == n - 1);
            r.text_done    = req.text_end && (k == n - 1);
            expected_q.push_back(r);
        end
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (expected_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected output request %h", got));
            return;
        end
        want = expected_q.pop_front();
        if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %h, expected %h",
                                      got.out_byte, want.out_byte));
        if (got.byte_present !== want.byte_present)
            report_mismatch($sformatf("byte_present %b, expected %b",
                                      got.byte_present, want.byte_present));
        if (got.run_last !== want.run_last)
            report_mismatch($sformatf("run_last %b, expected %b",
                                      got.run_last, want.run_last));
        if (got.text_done !== want.text_done)
            report_mismatch($sformatf("text_done %b, expected %b",
                                      got.text_done, want.text_done));
    endtask

    // Sample everything at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_bytes      = '0;
            pat_len        = '0;
            rep_bytes      = '0;
            rep_len        = '0;
            window_fill    = 0;
            expected_q.delete();
            mismatch_count = 0;
            pending_count  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PATTERN_BYTES:      pat_bytes = cfg_data;
                    CFG_PATTERN_LENGTH:
                    begin
                        pat_len     = cfg_data[LEN_W-1:0];
                        window_fill = 0;    // new length drops the window
                    end
                    CFG_REPLACEMENT_BYTES:  rep_bytes = cfg_data;
                    CFG_REPLACEMENT_LENGTH: rep_len   = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (text_valid && text_ready)
                predict_rewrite(text);
            if (result_valid && result_ready)
                check_result(result);
            pending_count = expected_q.size();
        end
    end

endmodule

// ===== sim/stream_find_and_replace_tb.sv =====
// ============================================================================
// stream_find_and_replace_tb
// Drives the find-and-replace block with a short directed sequence and then
// phases of random text rich in pattern occurrences, under several register
// settings and random stalls on both channels; the checker beside the block
// does all prediction and comparison.
// ============================================================================
`timescale 1ns / 1ps

module stream_find_and_replace_tb;
    import sfr_pkg::*;

    localparam int MAX_GAP       = 13;
    localparam int RANDOM_ITEMS  = 410;
    localparam int RANDOM_PHASES = 10;
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 600000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  text_valid;
    logic                  text_ready;
    text_t                 text;
    logic                  result_valid;
    logic                  result_ready;
    result_t               result;
    int unsigned           mismatch_count;
    int unsigned           pending_count;

    int unsigned           cycle_count = 0;
    bit                    calm;          // no stalls on either side
    logic [CFG_DATA_W-1:0] cur_pattern;   // pattern as last written
    int                    cur_plen;      // effective pattern length
    int                    sent_count;

    stream_find_and_replace uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .text_valid   (text_valid),
        .text_ready   (text_ready),
        .text         (text),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    rewrite_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .text_valid     (text_valid),
        .text_ready     (text_ready),
        .text           (text),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result         (result),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int draw_gap();
        if (calm || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Receiver: random stall before each output request
    initial
    begin
        int gap;
        result_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            gap = draw_gap();
            if (gap > 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!(result_valid && result_ready));
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_PATTERN_BYTES)
            cur_pattern = value;
        if (idx == CFG_PATTERN_LENGTH)
            cur_plen = (value[LEN_W-1:0] > MAX_PATTERN) ? MAX_PATTERN
                                                       : int'(value[LEN_W-1:0]);
    endtask

    task automatic set_registers(input logic [CFG_DATA_W-1:0] pat, input int plen,
                                 input logic [CFG_DATA_W-1:0] rep, input int rlen);
        write_reg(CFG_PATTERN_BYTES, pat);
        write_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(plen));
        write_reg(CFG_REPLACEMENT_BYTES, rep);
        write_reg(CFG_REPLACEMENT_LENGTH, CFG_DATA_W'(rlen));
    endtask

    // One input request, with a random gap in front
    task automatic send_byte(input logic [7:0] b, input logic last);
        text_t req;
        int    gap;
        req.text_byte = b;
        req.text_end  = last;
        @(negedge clk);
        gap = draw_gap();
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        text       <= req;
        text_valid <= 1'b1;
        do @(posedge clk); while (!(text_valid && text_ready));
        sent_count++;
    endtask

    // Let everything owed come out, then wait SETTLE_CYCLES for silent items
    task automatic settle();
        @(negedge clk);
        text_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [7:0] pattern_char();
        int k;
        k = $urandom_range(0, 7);
        return cur_pattern[8*k +: 8];
    endfunction

    // Random text: mostly whole or partial pattern copies, some noise
    task automatic send_random_text(input int count);
        int stop_at;
        int kind;
        int len;
        int k;
        stop_at = sent_count + count;
        while (sent_count < stop_at)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 5 && cur_plen > 0)
                len = cur_plen;
            else if (kind < 7 && cur_plen > 1)
                len = $urandom_range(1, cur_plen - 1);
            else
                len = 0;
            if (len > 0)
            begin
                for (k = 0; k < len; k++)
                    send_byte(cur_pattern[8*k +: 8], $urandom_range(0, 15) == 0);
            end
            else if ($urandom_range(0, 1) == 0)
                send_byte(pattern_char(), $urandom_range(0, 15) == 0);
            else
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        int                    p;
        int                    plen;
        int                    rlen;
        int                    base;
        int                    k;
        logic [CFG_DATA_W-1:0] pat;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        text_valid  = 1'b0;
        text        = '0;
        calm        = 1'b0;
        cur_pattern = '0;
        cur_plen    = 0;
        sent_count  = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Registers at reset: pass-through
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h5A, 1'b1);
        settle();

        // "ab" -> "XYZ": match, miss, partial overlap, flush at end
        set_registers(64'h6261, 2, 64'h5A5958, 3);
        send_byte("a", 1'b0);
        send_byte("b", 1'b0);
        send_byte("c", 1'b0);
        send_byte("a", 1'b0);
        send_byte("a", 1'b0);
        send_byte("b", 1'b0);
        send_byte("x", 1'b0);
        send_byte("a", 1'b1);
        // leave a byte pending, then rewriting the length must drop it
        send_byte("a", 1'b0);
        settle();
        write_reg(CFG_PATTERN_LENGTH, 64'd2);
        send_byte("b", 1'b0);
        send_byte("q", 1'b1);
        settle();

        // Length above the window saturates; empty replacement at end of text
        set_registers({CFG_DATA_W{1'b1}}, 15, '0, 0);
        for (k = 0; k < 7; k++)
            send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        settle();

        // Replacement length above eight saturates to eight
        set_registers('0, 1, {$urandom, $urandom}, 15);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        settle();

        // Random phases
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            calm = (p % 3 == 2);
            case (p)
                1:       plen = MAX_PATTERN;
                2:       plen = 0;
                3:       plen = 15;
                default:
                begin
                    k = $urandom_range(0, 9);
                    plen = (k == 0) ? 0 : (k == 1) ? $urandom_range(5, 15)
                                                   : $urandom_range(1, 4);
                end
            endcase
            case (p)
                4:       rlen = 0;
                5:       rlen = 15;
                6:       rlen = REPL_CAP;
                default:
                begin
                    rlen = $urandom_range(0, 9);
                    if (rlen == 9)
                        rlen = $urandom_range(9, 15);
                end
            endcase
            if (p == 7)
                pat = '0;
            else if (p == 8)
                pat = {CFG_DATA_W{1'b1}};
            else if ($urandom_range(0, 1) == 0)
                pat = {$urandom, $urandom};
            else
            begin
                // small alphabet makes near misses common
                base = $urandom_range(0, 253);
                for (k = 0; k < 8; k++)
                    pat[8*k +: 8] = 8'(base + $urandom_range(0, 2));
            end
            set_registers(pat, plen, {$urandom, $urandom}, rlen);
            send_random_text(RANDOM_ITEMS / RANDOM_PHASES);
            settle();
        end

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
